@@ sv/zsad_pkg.sv @@
// Shared types, constants and helpers for the z-score anomaly detector.
`default_nettype none
package zsad_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SCORE_W  = 11;
  localparam int SEV_W    = 3;
  localparam int STAMP_W  = 32;

  // Q0.10 value of 1.0 and the severity cutoffs 0.9, 0.7 and 0.5.
  localparam logic [SCORE_W-1:0] SCORE_ONE = 11'd1024;
  localparam logic [SCORE_W-1:0] CUT_CRIT  = 11'd921;
  localparam logic [SCORE_W-1:0] CUT_HIGH  = 11'd716;
  localparam logic [SCORE_W-1:0] CUT_MED   = 11'd512;

  localparam logic [SEV_W-1:0] SEV_NONE = 3'd0;
  localparam logic [SEV_W-1:0] SEV_LOW  = 3'd1;
  localparam logic [SEV_W-1:0] SEV_MED  = 3'd2;
  localparam logic [SEV_W-1:0] SEV_HIGH = 3'd3;
  localparam logic [SEV_W-1:0] SEV_CRIT = 3'd4;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_SCORE_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_MIN_SAMPLES     = 2'd1;
  localparam logic [1:0] REG_LEARNING_PERIOD = 2'd2;

  typedef struct packed {
    logic clr;
    logic acc_en;
    logic go;
  } chan_ctl_t;

  function automatic logic [SEV_W-1:0] severity_of(input logic [SCORE_W-1:0] sc,
                                                  input logic flag);
    logic [SEV_W-1:0] sev;
    sev = SEV_NONE;
    if (flag) begin
      if (sc > CUT_CRIT) sev = SEV_CRIT;
      else if (sc > CUT_HIGH) sev = SEV_HIGH;
      else if (sc > CUT_MED) sev = SEV_MED;
      else sev = SEV_LOW;
    end
    return sev;
  endfunction

endpackage
`default_nettype wire

@@ sv/zsad_serial_mul.sv @@
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
`default_nettype none
module zsad_serial_mul #(
  parameter int PW = 77,
  parameter int BW = 24
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [PW-1:0] a,
  input  wire logic [BW-1:0] b,
  output logic      [PW-1:0] prod,
  output logic               done
);
  localparam int CW = $clog2(BW + 1);

  logic [PW-1:0] acc;
  logic [PW-1:0] a_sh;
  logic [BW-1:0] b_sh;
  logic [CW-1:0] cnt;
  logic          busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // The product is complete in the cycle after the last multiplier bit.
      done <= busy && !start && (cnt == CW'(1));
      if (start) begin
        acc  <= '0;
        a_sh <= a;
        b_sh <= b;
        cnt  <= CW'(BW);
        busy <= 1'b1;
      end else if (busy) begin
        if (b_sh[0]) acc <= acc + a_sh;
        a_sh <= a_sh << 1;
        b_sh <= b_sh >> 1;
        cnt  <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign prod = acc;
endmodule
`default_nettype wire

@@ sv/zsad_chan.sv @@
// Per-channel window statistics and bit-serial z-score search.
`default_nettype none
module zsad_chan #(
  parameter int NW = 7
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire zsad_pkg::chan_ctl_t                 ctl,
  input  wire logic signed [zsad_pkg::SAMPLE_W-1:0] v,
  input  wire logic        [NW-1:0]                 n,
  input  wire logic signed [zsad_pkg::SAMPLE_W-1:0] x,
  output logic                                     done,
  output logic             [zsad_pkg::SCORE_W-1:0]  score
);
  localparam int SW = zsad_pkg::SAMPLE_W + NW;
  localparam int QW = 30 + NW;
  localparam int DW = 18 + NW;
  localparam int BW = 17 + NW;
  localparam int KW = 34 + 3 * NW;
  localparam int TW = KW + 22;

  typedef enum logic [3:0] {
    C_IDLE, C_NQ, C_S2, C_ND, C_DEV2, C_A, C_RA, C_RB
  } cstate_t;

  cstate_t state;

  logic signed [SW-1:0] s_acc;
  logic        [QW-1:0] q_acc;
  logic        [31:0]   sq;
  logic signed [DW-1:0] dev;
  logic signed [DW-1:0] n_s, x_s, s_s;
  logic        [BW-1:0] s_mag, dev_mag;
  logic        [TW-1:0] nq, k, rem, ks, delta;
  logic                 dz;
  logic        [3:0]    bitpos;
  logic        [zsad_pkg::SCORE_W-1:0] s;

  logic          m_start, m_done;
  logic [TW-1:0] m_a, m_prod;
  logic [BW-1:0] m_b;

  zsad_serial_mul #(.PW(TW), .BW(BW)) u_mul (
    .clk(clk), .rst(rst), .start(m_start), .a(m_a), .b(m_b),
    .prod(m_prod), .done(m_done)
  );

  assign sq      = 32'(32'(v) * 32'(v));
  assign n_s     = DW'(n);
  assign x_s     = DW'(x);
  assign s_s     = DW'(s_acc);
  assign s_mag   = BW'(s_acc[SW-1] ? -s_acc : s_acc);
  assign dev_mag = BW'(dev[DW-1] ? -dev : dev);

  // Window sum and sum of squares, one stored sample per cycle while acc_en is set.
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      s_acc <= '0;
      q_acc <= '0;
    end else if (ctl.acc_en) begin
      s_acc <= s_acc + SW'(v);
      q_acc <= q_acc + QW'(sq);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= C_IDLE;
      m_start <= 1'b0;
      done    <= 1'b0;
    end else begin
      // A product is started on the go request and after each of the first four products.
      m_start <= ((state == C_IDLE) && ctl.go) ||
                 ((state inside {C_NQ, C_S2, C_ND, C_DEV2}) && m_done);
      done    <= (state == C_RB) && (bitpos == 4'd0);
      unique case (state)
        C_IDLE: begin
          if (ctl.go) begin
            m_a     <= TW'(q_acc);
            m_b     <= BW'(n);
            dev     <= n_s * x_s - s_s;
            state   <= C_NQ;
          end
        end
        C_NQ: begin
          if (m_done) begin
            nq      <= m_prod;
            m_a     <= TW'(s_mag);
            m_b     <= s_mag;
            state   <= C_S2;
          end
        end
        C_S2: begin
          if (m_done) begin
            dz      <= (nq == m_prod);
            m_a     <= nq - m_prod;
            m_b     <= BW'(n);
            state   <= C_ND;
          end
        end
        C_ND: begin
          if (m_done) begin
            k       <= (m_prod << 3) + m_prod;
            m_a     <= TW'(dev_mag);
            m_b     <= dev_mag;
            state   <= C_DEV2;
          end
        end
        C_DEV2: begin
          if (m_done) begin
            m_a     <= m_prod;
            m_b     <= BW'(n) - BW'(1);
            state   <= C_A;
          end
        end
        C_A: begin
          if (m_done) begin
            rem    <= m_prod << 20;
            ks     <= '0;
            s      <= '0;
            bitpos <= 4'(zsad_pkg::SCORE_W - 1);
            state  <= C_RA;
          end
        end
        C_RA: begin
          // Growth of s^2*K when bit bitpos of s is set.
          delta <= (ks << (bitpos + 4'd1)) + (k << {bitpos, 1'b0});
          state <= C_RB;
        end
        C_RB: begin
          if (!s[zsad_pkg::SCORE_W-1] && delta <= rem) begin
            rem       <= rem - delta;
            ks        <= ks + (k << bitpos);
            s[bitpos] <= 1'b1;
          end
          if (bitpos == 4'd0) begin
            state <= C_IDLE;
          end else begin
            bitpos <= bitpos - 4'd1;
            state  <= C_RA;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  // A window with zero spread scores zero.
  assign score = dz ? '0 : s;
endmodule
`default_nettype wire

@@ sv/zscore_sensor_anomaly_detector_unit.sv @@
// Top level of the z-score anomaly detector for temperature and humidity samples.
// Usage:
// Input requests arrive on in_valid/in_stall with temperature, humidity,
// sample_valid, sample_time and now_ms; one result request per input leaves on
// out_valid/out_stall with anomaly, severity, score and result_time.
// Three registers sit on the APB-style port: score_threshold at 0x0,
// min_samples at 0x4 and learning_period_ms at 0x8; pready is always high.
// An invalid sample, a sample during learning, or one taken with fewer than
// min_samples stored gives an all-zero result, which goes through T_DONE to the output register.
// A scored sample first sweeps the stored window, one entry per cycle from
// the ring memories, then runs both channels in parallel, each through its
// own bit-serial multiplier (five products) and an 11-step restoring search
// for the score.
// One request is worked on at a time; in_stall is high while it is busy.
// The output register holds a finished result while the receiver stalls,
// and the next request may be accepted meanwhile; a second result waits
// until the first is taken. Reset empties the window, restarts learning,
// drops any pending result and restores the register defaults. The ring
// memories need no clearing: only entries already written are ever read.
`default_nettype none
module zscore_sensor_anomaly_detector_unit #(
  parameter int HISTORY_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic signed [15:0] temperature,
  input  wire logic signed [15:0] humidity,
  input  wire logic        sample_valid,
  input  wire logic [31:0] sample_time,
  input  wire logic [31:0] now_ms,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             anomaly,
  output logic [2:0]       severity,
  output logic [10:0]      score,
  output logic [31:0]      result_time
);
  localparam int NW = $clog2(HISTORY_DEPTH + 1);
  localparam int AW = $clog2(HISTORY_DEPTH);

  typedef enum logic [2:0] {T_IDLE, T_READ, T_LAST, T_CALC, T_DONE} tstate_t;

  tstate_t state;

  // Configuration registers.
  logic [10:0] score_threshold;
  logic [6:0]  min_samples;
  logic [31:0] learning_period_ms;

  // Detector state.
  logic [AW-1:0] write_pointer;
  logic [NW-1:0] stored_count;
  logic          learning;
  logic [31:0]   learn_start_ms;
  logic          start_captured;

  // Ring memories of the last samples.
  logic signed [15:0] temp_ring  [HISTORY_DEPTH];
  logic signed [15:0] humid_ring [HISTORY_DEPTH];
  logic signed [15:0] t_rd, h_rd;
  logic [AW-1:0]      raddr;
  logic               mem_we;

  // Sample under work and its staged result.
  logic signed [15:0] x_t, x_h;
  logic [31:0]        stamp;
  logic [NW-1:0]      n;
  logic               res_anomaly;
  logic [2:0]         res_sev;
  logic [10:0]        res_score;
  logic [31:0]        res_time;

  zsad_pkg::chan_ctl_t ctl;
  logic                rd_pend;
  logic                t_done, h_done, t_seen, h_seen;
  logic [10:0]         t_score, h_score, best;

  logic          accept;
  logic          cfg_wr;
  logic [31:0]   elapsed;
  logic [NW-1:0] count_next;
  logic          still_learning;
  logic          detect;

  assign pready   = 1'b1;
  assign in_stall = (state != T_IDLE);
  assign accept   = in_valid && !in_stall;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign mem_we   = accept && sample_valid;

  always_comb begin
    case (paddr[3:2])
      zsad_pkg::REG_SCORE_THRESHOLD: prdata = 32'(score_threshold);
      zsad_pkg::REG_MIN_SAMPLES:     prdata = 32'(min_samples);
      zsad_pkg::REG_LEARNING_PERIOD: prdata = learning_period_ms;
      default:                       prdata = '0;
    endcase
  end

  // The first valid sample opens the learning window, so its elapsed time is zero.
  assign elapsed = start_captured ? (now_ms - learn_start_ms) : 32'd0;
  assign count_next = (stored_count == NW'(HISTORY_DEPTH)) ? stored_count
                                                           : stored_count + NW'(1);
  assign still_learning = learning && (elapsed < learning_period_ms);
  assign detect = !still_learning && !(32'(count_next) < 32'(min_samples));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      temp_ring[write_pointer]  <= temperature;
      humid_ring[write_pointer] <= humidity;
    end
    t_rd <= temp_ring[raddr];
    h_rd <= humid_ring[raddr];
  end

  assign best = (t_score > h_score) ? t_score : h_score;

  zsad_chan #(.NW(NW)) u_chan_t (
    .clk(clk), .rst(rst), .ctl(ctl), .v(t_rd), .n(n), .x(x_t),
    .done(t_done), .score(t_score)
  );

  zsad_chan #(.NW(NW)) u_chan_h (
    .clk(clk), .rst(rst), .ctl(ctl), .v(h_rd), .n(n), .x(x_h),
    .done(h_done), .score(h_score)
  );

  always_comb begin
    ctl        = '0;
    ctl.acc_en = rd_pend;
    ctl.clr    = (state == T_READ) && !rd_pend && (raddr == '0);
    ctl.go     = (state == T_CALC) && !t_seen && !h_seen && !t_done && !h_done
                 && !rd_pend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= T_IDLE;
      score_threshold    <= 11'd717;
      min_samples        <= 7'd10;
      learning_period_ms <= 32'd60000;
      write_pointer      <= '0;
      stored_count       <= '0;
      learning           <= 1'b1;
      learn_start_ms     <= '0;
      start_captured     <= 1'b0;
      out_valid          <= 1'b0;
      rd_pend            <= 1'b0;
      t_seen             <= 1'b0;
      h_seen             <= 1'b0;
      raddr              <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[3:2])
          zsad_pkg::REG_SCORE_THRESHOLD: score_threshold    <= pwdata[10:0];
          zsad_pkg::REG_MIN_SAMPLES:     min_samples        <= pwdata[6:0];
          zsad_pkg::REG_LEARNING_PERIOD: learning_period_ms <= pwdata;
          default: ;
        endcase
      end

      // A taken result empties the output register unless the next one moves in.
      if (out_valid && !out_stall && (state != T_DONE)) out_valid <= 1'b0;

      unique case (state)
        T_IDLE: begin
          if (accept) begin
            res_anomaly <= 1'b0;
            res_sev     <= zsad_pkg::SEV_NONE;
            res_score   <= '0;
            res_time    <= '0;
            state       <= T_DONE;
            if (sample_valid) begin
              write_pointer <= (write_pointer == AW'(HISTORY_DEPTH - 1)) ? '0
                               : write_pointer + AW'(1);
              stored_count  <= count_next;
              if (!start_captured) begin
                start_captured <= 1'b1;
                learn_start_ms <= now_ms;
              end
              if (learning && !still_learning) learning <= 1'b0;
              if (detect) begin
                x_t   <= temperature;
                x_h   <= humidity;
                stamp <= sample_time;
                n     <= count_next;
                raddr <= '0;
                state <= T_READ;
              end
            end
          end
        end
        T_READ: begin
          rd_pend <= 1'b1;
          if (raddr == AW'(n - NW'(1))) state <= T_LAST;
          else raddr <= raddr + AW'(1);
        end
        T_LAST: begin
          rd_pend <= 1'b0;
          state   <= T_CALC;
        end
        T_CALC: begin
          if ((t_seen || t_done) && (h_seen || h_done)) begin
            t_seen      <= 1'b0;
            h_seen      <= 1'b0;
            res_score   <= best;
            res_anomaly <= best > score_threshold;
            res_sev     <= zsad_pkg::severity_of(best, best > score_threshold);
            res_time    <= stamp;
            state       <= T_DONE;
          end else begin
            if (t_done) t_seen <= 1'b1;
            if (h_done) h_seen <= 1'b1;
          end
        end
        T_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            anomaly     <= res_anomaly;
            severity    <= res_sev;
            score       <= res_score;
            result_time <= res_time;
            state       <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ sv/zsad_checker.sv @@
// Port-level checks of the anomaly detector and their binding to the top level.
`default_nettype none
module zsad_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        pready,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        anomaly,
  input wire logic [2:0]  severity,
  input wire logic [10:0] score
);
  a_sev_matches_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (anomaly == (severity != 3'd0)))
    else $error("severity disagrees with anomaly flag");

  a_score_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (score <= 11'd1024))
    else $error("score above 1.0");

  a_zero_not_flagged: assert property (@(posedge clk) disable iff (rst)
    (out_valid && score == 11'd0) |-> !anomaly)
    else $error("zero score flagged");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(score) && $stable(anomaly)))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid && pready))
    else $error("result pending after reset");
endmodule

bind zscore_sensor_anomaly_detector_unit zsad_checker u_zsad_checker (.*);
`default_nettype wire
